>>> hdl/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants, codes and controller/datapath interface types for the
// multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int TOP_LEVEL_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam int REQ_W       = 2;
  localparam int ID_FIELD_W  = 8;
  localparam int LVL_W       = 3;
  localparam int SLICE_OUT_W = 5;
  localparam int STAT_W      = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_YIELD = 2'd2;
  localparam logic [REQ_W-1:0] REQ_EXIT  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_IDLE_TICK = 2'd2;

  localparam logic [1:0] PUSH_IN   = 2'd0;
  localparam logic [1:0] PUSH_DOWN = 2'd1;
  localparam logic [1:0] PUSH_UP   = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       push;
    logic [1:0] push_sel;
    logic       tick_dec;
    logic       idle_tick;
    logic       clear_cur;
    logic       disp_sel;
    logic       disp_load;
    logic       load_out;
  } mfs_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             cur_valid;
    logic             slice_exp;
    logic             any_ready;
  } mfs_stat_t;

endpackage

>>> hdl/mfs_ram.sv
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mfs_ctrl.sv
// ----------------------------------------------------------------------------
// mfs_ctrl
// Sequencing state machine: accept, execute, select level, load, deliver.
// ----------------------------------------------------------------------------
module mfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mfs_pkg::mfs_stat_t stat,
  output mfs_pkg::mfs_cmd_t  cmd
);
  import mfs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_DSEL  = 3'd2;
  localparam logic [2:0] ST_DLOAD = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.req)
          REQ_ADD: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PUSH_IN;
            state_nxt    = ST_FIN;
          end
          REQ_TICK: begin
            if (!stat.cur_valid) begin
              cmd.idle_tick = 1'b1;
              state_nxt     = ST_FIN;
            end else if (stat.slice_exp) begin
              cmd.push      = 1'b1;
              cmd.push_sel  = PUSH_DOWN;
              cmd.clear_cur = 1'b1;
              state_nxt     = ST_DSEL;
            end else begin
              cmd.tick_dec = 1'b1;
              state_nxt    = ST_FIN;
            end
          end
          REQ_YIELD: begin
            cmd.push      = stat.cur_valid;
            cmd.push_sel  = PUSH_UP;
            cmd.clear_cur = 1'b1;
            state_nxt     = ST_DSEL;
          end
          default: begin
            cmd.clear_cur = 1'b1;
            state_nxt     = ST_DSEL;
          end
        endcase
      end
      ST_DSEL: begin
        cmd.disp_sel = 1'b1;
        state_nxt    = stat.any_ready ? ST_DLOAD : ST_FIN;
      end
      ST_DLOAD: begin
        cmd.disp_load = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hdl/mfs_dp.sv
// ----------------------------------------------------------------------------
// mfs_dp
// Scheduler datapath: queue pointers and counts, running process registers,
// level priority encoder, queue storage and result register.
// ----------------------------------------------------------------------------
module mfs_dp #(
  parameter int TOP_LEVEL   = mfs_pkg::TOP_LEVEL_DEF,
  parameter int QUEUE_DEPTH = mfs_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = mfs_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mfs_pkg::REQ_W-1:0]       in_req,
  input  logic [mfs_pkg::ID_FIELD_W-1:0]  in_id,
  input  logic [mfs_pkg::LVL_W-1:0]       in_lvl,
  input  mfs_pkg::mfs_cmd_t               cmd,
  output mfs_pkg::mfs_stat_t              stat,
  output logic [mfs_pkg::OUT_DATA_W-1:0]  out_data
);
  import mfs_pkg::*;

  localparam int NUM_LEVELS = TOP_LEVEL + 1;
  localparam int LI_W       = $clog2(NUM_LEVELS);
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int AW         = $clog2(RAM_DEPTH);
  localparam int SLICE_W    = TOP_LEVEL + 1;
  localparam int ID_W       = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam logic [LVL_W-1:0] TOP_LV = LVL_W'(TOP_LEVEL);

  logic [REQ_W-1:0]   req_r;
  logic [ID_W-1:0]    id_in_r;
  logic [LVL_W-1:0]   lvl_in_r;
  logic [PTR_W-1:0]   head_r [NUM_LEVELS];
  logic [PTR_W-1:0]   head_nxt [NUM_LEVELS];
  logic [PTR_W-1:0]   tail_r [NUM_LEVELS];
  logic [PTR_W-1:0]   tail_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]   cnt_r [NUM_LEVELS];
  logic [CNT_W-1:0]   cnt_nxt [NUM_LEVELS];
  logic               cur_valid_r, cur_valid_nxt;
  logic [ID_W-1:0]    cur_id_r, cur_id_nxt;
  logic [LVL_W-1:0]   cur_lvl_r, cur_lvl_nxt;
  logic [SLICE_W-1:0] cur_slice_r, cur_slice_nxt;
  logic [LVL_W-1:0]   disp_lvl_r, disp_lvl_nxt;
  logic               sw_r, sw_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [LVL_W-1:0]   push_lvl;
  logic [LI_W-1:0]    push_idx;
  logic [ID_W-1:0]    push_id;
  logic               push_ok;
  logic               push_we;
  logic [LVL_W-1:0]   sel_lvl;
  logic [LI_W-1:0]    sel_idx;
  logic               any_ready;
  logic [AW-1:0]      waddr, raddr;
  logic [ID_W-1:0]    rdata;

  // push level select and space check
  always_comb begin
    case (cmd.push_sel)
      PUSH_IN: begin
        push_lvl = (lvl_in_r > TOP_LV) ? TOP_LV : lvl_in_r;
        push_id  = id_in_r;
      end
      PUSH_DOWN: begin
        push_lvl = (cur_lvl_r == '0) ? '0 : cur_lvl_r - 1'b1;
        push_id  = cur_id_r;
      end
      PUSH_UP: begin
        push_lvl = (cur_lvl_r >= TOP_LV) ? TOP_LV : cur_lvl_r + 1'b1;
        push_id  = cur_id_r;
      end
      default: begin
        push_lvl = '0;
        push_id  = cur_id_r;
      end
    endcase
  end

  assign push_idx = push_lvl[LI_W-1:0];
  assign push_ok  = cnt_r[push_idx] != CNT_W'(QUEUE_DEPTH);
  assign push_we  = cmd.push && push_ok;
  assign waddr    = AW'(push_idx) * AW'(QUEUE_DEPTH) + AW'(tail_r[push_idx]);

  // highest non-empty level
  always_comb begin
    sel_lvl   = '0;
    any_ready = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        sel_lvl   = LVL_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  assign sel_idx = sel_lvl[LI_W-1:0];
  assign raddr   = AW'(sel_idx) * AW'(QUEUE_DEPTH) + AW'(head_r[sel_idx]);

  mfs_ram #(
    .WIDTH (ID_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (waddr),
    .wdata (push_id),
    .re    (cmd.disp_sel),
    .raddr (raddr),
    .rdata (rdata)
  );

  // queue pointers and counts
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push_we) begin
      tail_nxt[push_idx] = (tail_r[push_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                           : tail_r[push_idx] + 1'b1;
      cnt_nxt[push_idx]  = cnt_r[push_idx] + 1'b1;
    end
    if (cmd.disp_sel && any_ready) begin
      head_nxt[sel_idx] = (head_r[sel_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : head_r[sel_idx] + 1'b1;
      cnt_nxt[sel_idx]  = cnt_r[sel_idx] - 1'b1;
    end
  end

  // running process, flags
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_id_nxt    = cur_id_r;
    cur_lvl_nxt   = cur_lvl_r;
    cur_slice_nxt = cur_slice_r;
    disp_lvl_nxt  = disp_lvl_r;
    sw_nxt        = sw_r;
    status_nxt    = status_r;
    if (cmd.latch_in) begin
      sw_nxt     = 1'b0;
      status_nxt = STAT_OK;
    end
    if (cmd.push && !push_ok) begin
      status_nxt = STAT_FULL;
    end
    if (cmd.idle_tick) begin
      status_nxt = STAT_IDLE_TICK;
    end
    if (cmd.tick_dec) begin
      cur_slice_nxt = cur_slice_r - 1'b1;
    end
    if (cmd.clear_cur) begin
      cur_valid_nxt = 1'b0;
      cur_id_nxt    = '0;
      cur_lvl_nxt   = '0;
      cur_slice_nxt = '0;
    end
    if (cmd.disp_sel) begin
      disp_lvl_nxt = sel_lvl;
    end
    if (cmd.disp_load) begin
      cur_valid_nxt = 1'b1;
      cur_id_nxt    = rdata;
      cur_lvl_nxt   = disp_lvl_r;
      cur_slice_nxt = SLICE_W'(1) << (TOP_LV - disp_lvl_r);
      sw_nxt        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      cur_valid_r <= 1'b0;
      cur_id_r    <= '0;
      cur_lvl_r   <= '0;
      cur_slice_r <= '0;
      sw_r        <= 1'b0;
      status_r    <= STAT_OK;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_id_r    <= cur_id_nxt;
      cur_lvl_r   <= cur_lvl_nxt;
      cur_slice_r <= cur_slice_nxt;
      sw_r        <= sw_nxt;
      status_r    <= status_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    disp_lvl_r <= disp_lvl_nxt;
    if (cmd.latch_in) begin
      req_r    <= in_req;
      id_in_r  <= in_id[ID_W-1:0];
      lvl_in_r <= in_lvl;
    end
    if (cmd.load_out) begin
      out_data_r <= OUT_DATA_W'({status_r,
                     cur_valid_r ? SLICE_OUT_W'(cur_slice_r) : SLICE_OUT_W'(0),
                     cur_valid_r ? cur_lvl_r : LVL_W'(0),
                     cur_valid_r ? ID_FIELD_W'(cur_id_r) : ID_FIELD_W'(0),
                     cur_valid_r,
                     sw_r});
    end
  end

  assign stat.req       = req_r;
  assign stat.cur_valid = cur_valid_r;
  assign stat.slice_exp = cur_slice_r <= SLICE_W'(1);
  assign stat.any_ready = any_ready;
  assign out_data       = out_data_r;

endmodule

>>> hdl/multilevel_feedback_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// Multilevel feedback queue scheduler: one id fifo per priority level,
// running process with time slice, demotion on expiry, promotion on yield.
//
//   channel | direction | handshake          | contents
//   in_     | sink      | in_tvalid/tready   | tdata: id, level; tuser: request
//   out_    | source    | out_tvalid/tready  | tdata: run state and status
//
// add, idle tick and non-expiring tick go from execute straight to the result step;
// yield, exit and expiring tick pass level select and, if a level is ready, queue ram load.
// one request in flight at a time; the next is accepted while a result waits.
// the last step waits for the output register to be free when out_tready stalls.
// synchronous active-low reset empties all queues, no clearing pass needed.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core #(
  parameter int TOP_LEVEL   = mfs_pkg::TOP_LEVEL_DEF,
  parameter int QUEUE_DEPTH = mfs_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = mfs_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mfs_pkg::IN_DATA_W-1:0]  in_tdata,   // proc_id, start_level
  input  logic [mfs_pkg::REQ_W-1:0]      in_tuser,   // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // switched, run_valid, run_id, run_level, slice_left, status
  output logic [mfs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mfs_pkg::*;

  mfs_cmd_t  cmd;
  mfs_stat_t stat;

  mfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mfs_dp #(
    .TOP_LEVEL   (TOP_LEVEL),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_tuser),
    .in_id    (in_tdata[ID_FIELD_W-1:0]),
    .in_lvl   (in_tdata[ID_FIELD_W +: LVL_W]),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule

>>> bench/multilevel_feedback_scheduler_checker.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_checker
// Watches the request and result streams of the scheduler core, keeps its own
// model of the per-level id fifos and the running process, and compares every
// result beat field by field with the oldest predicted run report.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [mfs_pkg::IN_DATA_W-1:0]  in_tdata,   // proc_id, start_level
  input  logic [mfs_pkg::REQ_W-1:0]      in_tuser,   // req_type
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // switched, run_valid, run_id, run_level, slice_left, status
  input  logic [mfs_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             outstanding
);
  import mfs_pkg::*;

  localparam int TOP   = TOP_LEVEL_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic                    switched;
    logic                    run_valid;
    logic [ID_FIELD_W-1:0]   run_id;
    logic [LVL_W-1:0]        run_level;
    logic [SLICE_OUT_W-1:0]  slice_left;
    logic [STAT_W-1:0]       status;
  } run_report_t;

  logic [ID_FIELD_W-1:0]  level_fifo [0:TOP][0:DEPTH-1];
  int unsigned            fifo_head  [0:TOP];
  int unsigned            fifo_tail  [0:TOP];
  int unsigned            fifo_count [0:TOP];
  logic [ID_FIELD_W-1:0]  running_id;
  int unsigned            running_level;
  logic [SLICE_OUT_W-1:0] running_slice;
  bit                     running;
  run_report_t            expected_runs[$];
  int                     err_cnt = 0;

  function bit enqueue_proc(int unsigned lv, logic [ID_FIELD_W-1:0] id);
    int unsigned l;
    l = (lv > TOP) ? TOP : lv;
    if (fifo_count[l] >= DEPTH) return 0;
    level_fifo[l][fifo_tail[l]] = id;
    fifo_tail[l] = (fifo_tail[l] + 1) % DEPTH;
    fifo_count[l]++;
    return 1;
  endfunction

  function bit dispatch_highest();
    for (int lv = TOP; lv >= 0; lv--) begin
      if (fifo_count[lv] != 0) begin
        running_id    = level_fifo[lv][fifo_head[lv]];
        fifo_head[lv] = (fifo_head[lv] + 1) % DEPTH;
        fifo_count[lv]--;
        running_level = lv;
        running_slice = SLICE_OUT_W'(1 << (TOP - lv));
        running       = 1;
        return 1;
      end
    end
    running       = 0;
    running_id    = '0;
    running_level = 0;
    running_slice = '0;
    return 0;
  endfunction

  task predict_request(logic [REQ_W-1:0] req, logic [ID_FIELD_W-1:0] id,
                       logic [LVL_W-1:0] lvl);
    run_report_t r;
    logic [STAT_W-1:0] st;
    bit sw;
    int unsigned nl;
    st = STAT_OK;
    sw = 0;
    case (req)
      REQ_ADD: begin
        if (!enqueue_proc(lvl, id)) st = STAT_FULL;
      end
      REQ_TICK: begin
        if (!running) begin
          st = STAT_IDLE_TICK;
        end else begin
          if (running_slice != 0) running_slice--;
          if (running_slice == 0) begin
            nl = (running_level == 0) ? 0 : running_level - 1;
            if (!enqueue_proc(nl, running_id)) st = STAT_FULL;
            running = 0;
            sw = dispatch_highest();
          end
        end
      end
      REQ_YIELD: begin
        if (running) begin
          nl = (running_level >= TOP) ? TOP : running_level + 1;
          if (!enqueue_proc(nl, running_id)) st = STAT_FULL;
          running = 0;
        end
        sw = dispatch_highest();
      end
      default: begin
        running = 0;
        sw = dispatch_highest();
      end
    endcase
    r.switched   = sw;
    r.run_valid  = running;
    r.run_id     = running ? running_id : '0;
    r.run_level  = running ? LVL_W'(running_level) : '0;
    r.slice_left = running ? running_slice : '0;
    r.status     = st;
    expected_runs.push_back(r);
  endtask

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    run_report_t want;
    run_report_t got;
    if (!rst_n) begin
      for (int l = 0; l <= TOP; l++) begin
        fifo_head[l]  = 0;
        fifo_tail[l]  = 0;
        fifo_count[l] = 0;
      end
      running       = 0;
      running_id    = '0;
      running_level = 0;
      running_slice = '0;
      expected_runs.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = run_report_t'(out_tdata[19:0]);
        if (expected_runs.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = expected_runs.pop_front();
          check_field("switched", want.switched, out_tdata[0]);
          check_field("run_valid", want.run_valid, out_tdata[1]);
          check_field("run_id", want.run_id, out_tdata[9:2]);
          check_field("run_level", want.run_level, out_tdata[12:10]);
          check_field("slice_left", want.slice_left, out_tdata[17:13]);
          check_field("status", want.status, out_tdata[19:18]);
          check_field("padding", 0, out_tdata[23:20]);
        end
      end
      if (in_tvalid && in_tready)
        predict_request(in_tuser, in_tdata[7:0], in_tdata[10:8]);
    end
    outstanding <= expected_runs.size();
    mismatches  <= err_cnt;
  end

endmodule

>>> bench/multilevel_feedback_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core_tb
// Drives request beats into the scheduler core: a directed opening over idle
// requests, level saturation, promotion, demotion and draining, then random
// phases that fill, tick, yield and drain the level fifos, with random gaps
// on both streams. The checker predicts and compares; this top gives verdict.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core_tb;
  import mfs_pkg::*;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // proc_id, start_level
  logic [REQ_W-1:0]      in_tuser = '0;   // req_type
  logic                  out_tready = 0;
  logic                  in_tready;
  logic                  out_tvalid;
  // switched, run_valid, run_id, run_level, slice_left, status
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatches;
  int                    outstanding;
  bit                    calm = 0;

  always #1 clk = ~clk;

  multilevel_feedback_scheduler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  multilevel_feedback_scheduler_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    #2000000;
    $display("multilevel_feedback_scheduler_core verification failed");
    $finish;
  end

  // result side stalls
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (calm || !rst_n) begin
        out_tready <= 1;
      end else if (hold > 0) begin
        out_tready <= 0;
        hold--;
      end else if ($urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_req(logic [REQ_W-1:0] req, logic [7:0] id, logic [LVL_W-1:0] lvl);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= req;
    in_tdata  <= {5'b0, lvl, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    int mode;
    int pick;
    int lo;
    logic [REQ_W-1:0] req;
    logic [LVL_W-1:0] lvl;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // requests with nothing running or queued
    send_req(REQ_TICK, 8'h00, 3'd0);
    send_req(REQ_YIELD, 8'hff, 3'd7);
    send_req(REQ_EXIT, 8'h5a, 3'd2);
    // adds at every level, levels above top saturate
    send_req(REQ_ADD, 8'h00, 3'd0);
    send_req(REQ_ADD, 8'hff, 3'd7);
    send_req(REQ_ADD, 8'haa, 3'd5);
    send_req(REQ_ADD, 8'h55, 3'd6);
    send_req(REQ_ADD, 8'h01, 3'd1);
    send_req(REQ_ADD, 8'h02, 3'd2);
    send_req(REQ_ADD, 8'h03, 3'd3);
    send_req(REQ_ADD, 8'h04, 3'd4);
    // dispatch, expire on top slice, yield (saturating at top), exit
    send_req(REQ_YIELD, 8'h00, 3'd0);
    send_req(REQ_TICK, 8'h00, 3'd0);
    send_req(REQ_YIELD, 8'h00, 3'd0);
    send_req(REQ_TICK, 8'h00, 3'd0);
    send_req(REQ_EXIT, 8'h00, 3'd0);
    // drain everything, then tick idle
    repeat (8) send_req(REQ_EXIT, 8'h00, 3'd0);
    send_req(REQ_TICK, 8'h00, 3'd0);

    for (int phase = 0; phase < 13; phase++) begin
      mode = (phase == 12) ? 0 : phase % 5;
      lo = $urandom_range(0, 4);
      if (phase == 12) calm = 1;
      for (int k = 0; k < 150; k++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          1:       req = pick < 75 ? REQ_ADD : pick < 87 ? REQ_TICK :
                         pick < 95 ? REQ_YIELD : REQ_EXIT;
          2:       req = pick < 25 ? REQ_ADD : pick < 85 ? REQ_TICK :
                         pick < 95 ? REQ_YIELD : REQ_EXIT;
          3:       req = pick < 10 ? REQ_ADD : pick < 40 ? REQ_TICK :
                         pick < 50 ? REQ_YIELD : REQ_EXIT;
          4:       req = pick < 35 ? REQ_ADD : pick < 55 ? REQ_TICK :
                         pick < 95 ? REQ_YIELD : REQ_EXIT;
          default: req = pick < 40 ? REQ_ADD : pick < 70 ? REQ_TICK :
                         pick < 85 ? REQ_YIELD : REQ_EXIT;
        endcase
        if ($urandom_range(0, 4) == 0)
          lvl = LVL_W'($urandom_range(5, 7));
        else if (mode == 1)
          lvl = LVL_W'(lo + $urandom_range(0, 1));
        else
          lvl = LVL_W'($urandom_range(0, 4));
        send_req(req, 8'($urandom_range(0, 255)), lvl);
      end
    end
    in_tvalid <= 0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("multilevel_feedback_scheduler_core verification clean");
    else
      $display("multilevel_feedback_scheduler_core verification failed");
    $finish;
  end

endmodule
